### hdl/eeu_pkg.sv
// shared types and constants for the exception entry unit
package eeu_pkg;

   localparam int unsigned DataWidth  = 32;
   localparam int unsigned CodeWidth  = 5;
   localparam int unsigned PageWidth  = 18;
   localparam int unsigned VpnWidth   = 19;
   localparam int unsigned IntWidth   = 8;
   localparam int unsigned KindWidth  = 2;
   localparam int unsigned AddrWidth  = 5;
   localparam int unsigned PageShift  = 12;
   localparam int unsigned VpnShift   = 13;

   localparam logic [DataWidth-1:0] BootBase     = 32'hbfc0_0200;
   localparam logic [DataWidth-1:0] Kseg0Bit     = 32'h8000_0000;
   localparam logic [DataWidth-1:0] OffsGeneral  = 32'h0000_0180;
   localparam logic [DataWidth-1:0] OffsVectored = 32'h0000_0200;
   localparam logic [DataWidth-1:0] OffsRefill   = 32'h0000_0000;
   localparam logic [DataWidth-1:0] SlotAdjust   = 32'h0000_0004;

   // exception codes
   localparam logic [CodeWidth-1:0] CodeInt  = 5'd0;
   localparam logic [CodeWidth-1:0] CodeMod  = 5'd1;
   localparam logic [CodeWidth-1:0] CodeTlbl = 5'd2;
   localparam logic [CodeWidth-1:0] CodeTlbs = 5'd3;
   localparam logic [CodeWidth-1:0] CodeAdel = 5'd4;
   localparam logic [CodeWidth-1:0] CodeAdes = 5'd5;

   // request kinds
   typedef enum logic [KindWidth-1:0] {
      REQ_RAISE  = 2'd0,
      REQ_QUERY  = 2'd1,
      REQ_RETURN = 2'd2
   } req_kind_type;

   // register indexes on the csr port
   typedef enum logic [2:0] {
      CSR_BOOT_VECTORS       = 3'd0,
      CSR_EXCEPTION_PAGE     = 3'd1,
      CSR_VECTORED_INTERRUPT = 3'd2,
      CSR_INTERRUPT_MASK     = 3'd3,
      CSR_INTERRUPT_ENABLE   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                 boot_vectors;
      logic [PageWidth-1:0] exception_page;
      logic                 vectored_interrupt;
      logic [IntWidth-1:0]  interrupt_mask;
      logic                 interrupt_enable;
   } cfg_type;

   typedef struct packed {
      logic [KindWidth-1:0] req_type;
      logic [CodeWidth-1:0] exc_code;
      logic [DataWidth-1:0] bad_vaddr;
      logic                 tlb_refill;
      logic [DataWidth-1:0] fault_pc;
      logic                 in_delay_slot;
      logic [IntWidth-1:0]  int_pending;
   } item_type;

   typedef struct packed {
      logic [DataWidth-1:0] next_pc;
      logic [DataWidth-1:0] saved_epc;
      logic                 branch_delay_flag;
      logic [CodeWidth-1:0] cause_code;
      logic [DataWidth-1:0] bad_address_reg;
      logic [VpnWidth-1:0]  page_pair_number;
      logic                 exception_level;
      logic                 take_interrupt;
   } result_type;

endpackage

### hdl/eeu_req_if.sv
// request channel interface
interface eeu_req_if import eeu_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [KindWidth-1:0] req_type;
   logic [CodeWidth-1:0] exc_code;
   logic [DataWidth-1:0] bad_vaddr;
   logic                 tlb_refill;
   logic [DataWidth-1:0] fault_pc;
   logic                 in_delay_slot;
   logic [IntWidth-1:0]  int_pending;

   modport source (
      output valid, req_type, exc_code, bad_vaddr, tlb_refill, fault_pc,
             in_delay_slot, int_pending,
      input  ready
   );
   modport sink (
      input  valid, req_type, exc_code, bad_vaddr, tlb_refill, fault_pc,
             in_delay_slot, int_pending,
      output ready
   );
endinterface

### hdl/eeu_rsp_if.sv
// result channel interface
interface eeu_rsp_if import eeu_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [DataWidth-1:0] next_pc;
   logic [DataWidth-1:0] saved_epc;
   logic                 branch_delay_flag;
   logic [CodeWidth-1:0] cause_code;
   logic [DataWidth-1:0] bad_address_reg;
   logic [VpnWidth-1:0]  page_pair_number;
   logic                 exception_level;
   logic                 take_interrupt;

   modport source (
      output valid, next_pc, saved_epc, branch_delay_flag, cause_code,
             bad_address_reg, page_pair_number, exception_level, take_interrupt,
      input  ready
   );
   modport sink (
      input  valid, next_pc, saved_epc, branch_delay_flag, cause_code,
             bad_address_reg, page_pair_number, exception_level, take_interrupt,
      output ready
   );
endinterface

### hdl/mips_exception_entry_unit_top.sv
// exception entry unit top level
// a request beat is held in the input register, then its result in the result register
// throughput: one request per cycle while each result is taken; a result left waiting stalls the input
// the input stage takes a new beat while a finished result waits to be taken only if it is empty
// reset: synchronous, active high; clears exl, epc, bd, cause code, badvaddr and vpn2,
// sets the boot-vector flag and clears the other configuration registers
module mips_exception_entry_unit_top import eeu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   eeu_req_if.sink              req_port,
   eeu_rsp_if.source            rsp_port,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [DataWidth-1:0] csr_pwdata,
   output logic [DataWidth-1:0] csr_prdata,
   output logic                 csr_pready
);

   cfg_type  cfg;
   logic     item_valid;
   item_type item;
   logic     item_take;

   eeu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   eeu_ingress u_ingress (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   eeu_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_port   (rsp_port)
   );

endmodule

### hdl/eeu_csr.sv
// apb configuration registers
module eeu_csr import eeu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [AddrWidth-1:0] paddr,
   input  logic [DataWidth-1:0] pwdata,
   output logic [DataWidth-1:0] prdata,
   output logic                 pready,
   output cfg_type              cfg
);

   cfg_type       cfg_ff, cfg_in;
   csr_index_type index;
   logic          write_en;

   assign pready   = 1'b1;
   assign index    = csr_index_type'(paddr[AddrWidth-1:2]);
   assign write_en = psel && penable && pwrite;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            CSR_BOOT_VECTORS:       cfg_in.boot_vectors       = pwdata[0];
            CSR_EXCEPTION_PAGE:     cfg_in.exception_page     = pwdata[PageWidth-1:0];
            CSR_VECTORED_INTERRUPT: cfg_in.vectored_interrupt = pwdata[0];
            CSR_INTERRUPT_MASK:     cfg_in.interrupt_mask     = pwdata[IntWidth-1:0];
            CSR_INTERRUPT_ENABLE:   cfg_in.interrupt_enable   = pwdata[0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (index)
         CSR_BOOT_VECTORS:       prdata[0] = cfg_ff.boot_vectors;
         CSR_EXCEPTION_PAGE:     prdata[PageWidth-1:0] = cfg_ff.exception_page;
         CSR_VECTORED_INTERRUPT: prdata[0] = cfg_ff.vectored_interrupt;
         CSR_INTERRUPT_MASK:     prdata[IntWidth-1:0] = cfg_ff.interrupt_mask;
         CSR_INTERRUPT_ENABLE:   prdata[0] = cfg_ff.interrupt_enable;
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.boot_vectors       <= 1'b1;
         cfg_ff.exception_page     <= '0;
         cfg_ff.vectored_interrupt <= 1'b0;
         cfg_ff.interrupt_mask     <= '0;
         cfg_ff.interrupt_enable   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hdl/eeu_ingress.sv
// input register stage
module eeu_ingress import eeu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   eeu_req_if.sink  req_port,
   output logic     item_valid,
   output item_type item,
   input  logic     item_take
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     load;

   assign req_port.ready = !valid_ff || item_take;
   assign load           = req_port.valid && req_port.ready;
   assign valid_in       = load || (valid_ff && !item_take);
   assign item_valid     = valid_ff;
   assign item           = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.req_type      <= req_port.req_type;
         item_ff.exc_code      <= req_port.exc_code;
         item_ff.bad_vaddr     <= req_port.bad_vaddr;
         item_ff.tlb_refill    <= req_port.tlb_refill;
         item_ff.fault_pc      <= req_port.fault_pc;
         item_ff.in_delay_slot <= req_port.in_delay_slot;
         item_ff.int_pending   <= req_port.int_pending;
      end
   end

endmodule

### hdl/eeu_exec.sv
// cp0 state, vector selection and result register
module eeu_exec import eeu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_take,
   eeu_rsp_if.source rsp_port
);

   logic                 level_ff, level_in;
   logic [DataWidth-1:0] epc_ff, epc_in;
   logic                 delay_ff, delay_in;
   logic [CodeWidth-1:0] code_ff, code_in;
   logic [DataWidth-1:0] badaddr_ff, badaddr_in;
   logic [VpnWidth-1:0]  vpn_ff, vpn_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           result_ff, result_in;

   logic                 tlb_miss;
   logic                 has_vpn;
   logic                 has_addr;
   logic [DataWidth-1:0] base;
   logic [DataWidth-1:0] offs;
   logic [DataWidth-1:0] vector;
   logic                 take;

   // result slot frees when empty or being drained this cycle
   assign item_take    = item_valid && (!rsp_valid_ff || rsp_port.ready);
   assign rsp_valid_in = item_take || (rsp_valid_ff && !rsp_port.ready);

   assign tlb_miss = (item.exc_code == CodeTlbl) || (item.exc_code == CodeTlbs);
   assign has_vpn  = tlb_miss || (item.exc_code == CodeMod);
   assign has_addr = has_vpn || (item.exc_code == CodeAdel) || (item.exc_code == CodeAdes);
   assign base     = cfg.boot_vectors ? BootBase
                   : (Kseg0Bit | ({{(DataWidth-PageWidth){1'b0}}, cfg.exception_page}
                                  << PageShift));
   assign vector   = base + offs;
   assign take     = (|(item.int_pending & cfg.interrupt_mask)) && !level_ff
                     && cfg.interrupt_enable;

   // nested raise always lands on the general offset
   always_comb begin
      offs = OffsGeneral;
      if (!level_ff) begin
         if (tlb_miss && item.tlb_refill) begin
            offs = OffsRefill;
         end else if ((item.exc_code == CodeInt) && cfg.vectored_interrupt) begin
            offs = OffsVectored;
         end
      end
   end

   always_comb begin
      level_in   = level_ff;
      epc_in     = epc_ff;
      delay_in   = delay_ff;
      code_in    = code_ff;
      badaddr_in = badaddr_ff;
      vpn_in     = vpn_ff;
      result_in  = result_ff;
      if (item_take) begin
         result_in.next_pc        = '0;
         result_in.take_interrupt = 1'b0;
         unique case (req_kind_type'(item.req_type))
            REQ_RAISE: begin
               if (!level_ff) begin
                  epc_in   = item.in_delay_slot ? (item.fault_pc - SlotAdjust)
                                                : item.fault_pc;
                  delay_in = item.in_delay_slot;
               end
               code_in  = item.exc_code;
               level_in = 1'b1;
               if (has_addr) begin
                  badaddr_in = item.bad_vaddr;
               end
               if (has_vpn) begin
                  vpn_in = item.bad_vaddr[DataWidth-1:VpnShift];
               end
               result_in.next_pc = vector;
            end
            REQ_QUERY: begin
               result_in.take_interrupt = take;
            end
            REQ_RETURN: begin
               level_in = 1'b0;
            end
            default: begin
               level_in = level_ff;
            end
         endcase
         result_in.saved_epc         = epc_in;
         result_in.branch_delay_flag = delay_in;
         result_in.cause_code        = code_in;
         result_in.bad_address_reg   = badaddr_in;
         result_in.page_pair_number  = vpn_in;
         result_in.exception_level   = level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= 1'b0;
         epc_ff       <= '0;
         delay_ff     <= 1'b0;
         code_ff      <= '0;
         badaddr_ff   <= '0;
         vpn_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         epc_ff       <= epc_in;
         delay_ff     <= delay_in;
         code_ff      <= code_in;
         badaddr_ff   <= badaddr_in;
         vpn_ff       <= vpn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_port.valid             = rsp_valid_ff;
   assign rsp_port.next_pc           = result_ff.next_pc;
   assign rsp_port.saved_epc         = result_ff.saved_epc;
   assign rsp_port.branch_delay_flag = result_ff.branch_delay_flag;
   assign rsp_port.cause_code        = result_ff.cause_code;
   assign rsp_port.bad_address_reg   = result_ff.bad_address_reg;
   assign rsp_port.page_pair_number  = result_ff.page_pair_number;
   assign rsp_port.exception_level   = result_ff.exception_level;
   assign rsp_port.take_interrupt    = result_ff.take_interrupt;

endmodule
